### sv/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only outside reset
`define NTCAT_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("ntcat assertion failed");

// property checked at every edge, reset included
`define NTCAT_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("ntcat assertion failed");

`endif

### sv/ntcat_pkg.sv
package ntcat_pkg;

   localparam int DEFAULT_ADC_BITS = 10;

   localparam int SHIFT_W = 4;
   localparam int BETA_W  = 14;
   localparam int TEMP_W  = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_SHIFT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA_VALUE    = 1'd1;

   localparam logic [SHIFT_W-1:0] SHIFT_RESET = 4'd4;
   localparam logic [BETA_W-1:0]  BETA_RESET  = 14'd3380;

   localparam logic signed [TEMP_W-1:0] TEMP_LOW  = -16'sd2731;
   localparam logic signed [TEMP_W-1:0] TEMP_HIGH = 16'sd20000;
   localparam logic [63:0] KELVIN_X10 = 64'd2731;
   localparam logic [63:0] Q_SAT      = 64'd22731;

   localparam logic [31:0] LN2_Q24 = 32'd11629080;
   localparam logic signed [63:0] INV_T25_Q56 = ((64'sd1 <<< 56) * 64'sd20) / 64'sd5963;
   localparam logic [63:0] TEN_Q56 = 64'd10 << 56;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [63:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [63:0] quotient;
      logic [63:0] remainder;
   } div_rsp_type;

endpackage

### sv/ntcat_if.sv
interface ntcat_req_if import ntcat_pkg::*; #(parameter int ADC_BITS = DEFAULT_ADC_BITS) ();
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] sample_local;
   logic [ADC_BITS-1:0] sample_remote;
   modport source (output valid, sample_local, sample_remote, input ready);
   modport sink (input valid, sample_local, sample_remote, output ready);
endinterface

interface ntcat_rsp_if import ntcat_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temp_local;
   logic signed [TEMP_W-1:0] temp_remote;
   logic [1:0]               rail_flags;
   modport source (output valid, temp_local, temp_remote, rail_flags, input ready);
   modport sink (input valid, temp_local, temp_remote, rail_flags, output ready);
endinterface

interface ntcat_csr_if import ntcat_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;
   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

### sv/ntcat_div.sv
module ntcat_div import ntcat_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [64:0] rem_ff, rem_in;
   logic [63:0] quo_ff, quo_in;
   logic [63:0] den_ff, den_in;

   always_comb begin
      logic [64:0] rem_sh;
      rem_sh  = {rem_ff[63:0], quo_ff[63]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = req.dividend;
         den_in  = req.divisor;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff[63:0];

endmodule

### sv/ntc_average_to_temperature_core.sv
// a sample beat that changes an average runs each channel through the full log and divide
// path, or a short path when that channel's average sits at a rail
// a new sample beat is taken only in idle, once the last result beat is loaded; the full path
// uses the 32-step log loop and the 64-step shared divider, each twice per channel
// no-change beats give no result; a held result beat stalls the sequencer in its last state
// reset: synchronous, active high; averages clear to zero, average_shift to 4, beta to 3380
module ntc_average_to_temperature_core import ntcat_pkg::*; #(
   parameter int ADC_BITS = DEFAULT_ADC_BITS
) (
   input logic        clock,
   input logic        reset,
   ntcat_req_if.sink  req_bus,
   ntcat_rsp_if.source rsp_bus,
   ntcat_csr_if.sink  csr_bus
);

   localparam int KW    = $clog2(ADC_BITS);
   localparam int LOG_W = KW + 32;
   localparam int SUM_W = ADC_BITS + 16;
   localparam logic [ADC_BITS-1:0] FULL_CODE = {ADC_BITS{1'b1}};

   // sequencer states
   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_CHAN      = 4'd1;
   localparam logic [3:0] S_LOG_INIT  = 4'd2;
   localparam logic [3:0] S_LOG_RUN   = 4'd3;
   localparam logic [3:0] S_MUL_LO    = 4'd4;
   localparam logic [3:0] S_MUL_HI    = 4'd5;
   localparam logic [3:0] S_DIV1      = 4'd6;
   localparam logic [3:0] S_DIV1_WAIT = 4'd7;
   localparam logic [3:0] S_CHECK     = 4'd8;
   localparam logic [3:0] S_DIV2_WAIT = 4'd9;
   localparam logic [3:0] S_NEXT      = 4'd10;
   localparam logic [3:0] S_OUT       = 4'd11;

   logic [3:0]          state_ff, state_in;
   logic                ch_ff, ch_in;
   logic                phase_ff, phase_in;
   logic [4:0]          cnt_ff, cnt_in;
   logic [30:0]         m_ff, m_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [31:0]         frac_ff, frac_in;
   logic [LOG_W-1:0]    la_ff, la_in;
   logic                xneg_ff, xneg_in;
   logic [LOG_W-1:0]    xmag_ff, xmag_in;
   logic [63:0]         acc_ff, acc_in;
   logic signed [63:0]  s_ff, s_in;
   logic signed [TEMP_W-1:0] temp_ff [2];
   logic signed [TEMP_W-1:0] temp_in [2];
   logic [1:0]          flag_ff, flag_in;
   logic [ADC_BITS-1:0] avg_ff [2];
   logic [ADC_BITS-1:0] avg_in [2];
   logic [SHIFT_W-1:0]  shift_ff, shift_in;
   logic [BETA_W-1:0]   beta_ff, beta_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0] rsp_tl_ff, rsp_tl_in, rsp_tr_ff, rsp_tr_in;
   logic [1:0]          rsp_flags_ff, rsp_flags_in;

   // shared multiplier
   logic [31:0] mul_a, mul_b;
   logic [63:0] mul_p;
   assign mul_p = 64'(mul_a) * 64'(mul_b);

   div_req_type div_req;
   div_rsp_type div_rsp;

   ntcat_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   logic [BETA_W-1:0] beta_eff;
   assign beta_eff = (beta_ff == '0) ? BETA_W'(1) : beta_ff;

   // divider launches: beta divide then the reciprocal divide
   always_comb begin
      div_req.start    = (state_ff == S_DIV1) || (state_ff == S_CHECK && s_ff > 64'sd0);
      div_req.dividend = (state_ff == S_DIV1) ? acc_ff : TEN_Q56;
      div_req.divisor  = (state_ff == S_DIV1) ? 64'(beta_eff) : s_ff;
   end

   logic req_take, csr_take, rsp_free;
   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;
   assign csr_take      = csr_bus.valid;
   assign rsp_free      = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      logic [ADC_BITS-1:0] smp [2];
      logic [SUM_W-1:0]    sum;
      logic [ADC_BITS-1:0] nv;
      logic                changed;
      logic [ADC_BITS-1:0] avg;
      logic [ADC_BITS-1:0] n;
      logic [KW-1:0]       kk;
      logic [63:0]         sq;
      logic [31:0]         t;
      logic [31:0]         frac_nx;
      logic [LOG_W-1:0]    lb;
      logic [63:0]         qs;
      logic signed [16:0]  v;

      state_in     = state_ff;
      ch_in        = ch_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      m_in         = m_ff;
      k_in         = k_ff;
      frac_in      = frac_ff;
      la_in        = la_ff;
      xneg_in      = xneg_ff;
      xmag_in      = xmag_ff;
      acc_in       = acc_ff;
      s_in         = s_ff;
      temp_in      = temp_ff;
      flag_in      = flag_ff;
      avg_in       = avg_ff;
      shift_in     = shift_ff;
      beta_in      = beta_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_tl_in    = rsp_tl_ff;
      rsp_tr_in    = rsp_tr_ff;
      rsp_flags_in = rsp_flags_ff;
      mul_a        = '0;
      mul_b        = '0;
      changed      = 1'b0;
      smp[0]       = req_bus.sample_local;
      smp[1]       = req_bus.sample_remote;
      avg          = avg_ff[ch_ff];
      n            = phase_ff ? (FULL_CODE - avg) : avg;
      kk           = '0;
      sq           = '0;
      t            = '0;
      frac_nx      = '0;
      lb           = '0;
      qs           = '0;
      v            = '0;

      // result taken downstream
      if (rsp_bus.ready) rsp_valid_in = 1'b0;

      // register writes
      if (csr_take) begin
         case (csr_bus.index)
            CSR_AVERAGE_SHIFT: shift_in = csr_bus.wdata[SHIFT_W-1:0];
            CSR_BETA_VALUE:    beta_in  = csr_bus.wdata[BETA_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               // running average: avg*(2^s-1) + sample, then shift down
               for (int c = 0; c < 2; c++) begin
                  sum = (SUM_W'(avg_ff[c]) << shift_ff) - SUM_W'(avg_ff[c]) + SUM_W'(smp[c]);
                  nv  = ADC_BITS'(sum >> shift_ff);
                  if (nv != avg_ff[c]) begin
                     avg_in[c] = nv;
                     changed   = 1'b1;
                  end
               end
               if (changed) begin
                  ch_in    = 1'b0;
                  state_in = S_CHAN;
               end
            end
         end
         S_CHAN: begin
            if (avg == '0 || avg == FULL_CODE) begin
               temp_in[ch_ff] = TEMP_LOW;
               flag_in[ch_ff] = 1'b1;
               state_in       = S_NEXT;
            end else begin
               flag_in[ch_ff] = 1'b0;
               phase_in       = 1'b0;
               state_in       = S_LOG_INIT;
            end
         end
         S_LOG_INIT: begin
            // integer part is the leading one position; mantissa into [2^30, 2^31)
            for (int i = 0; i < ADC_BITS; i++) begin
               if (n[i]) kk = KW'(i);
            end
            k_in     = kk;
            m_in     = 31'(n) << (5'd30 - 5'(kk));
            frac_in  = '0;
            cnt_in   = '0;
            state_in = S_LOG_RUN;
         end
         S_LOG_RUN: begin
            // square the mantissa, one fraction bit per cycle
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, m_ff};
            t     = mul_p[61:30];
            if (t[31]) begin
               m_in    = t[31:1];
               frac_nx = {frac_ff[30:0], 1'b1};
            end else begin
               m_in    = t[30:0];
               frac_nx = {frac_ff[30:0], 1'b0};
            end
            frac_in = frac_nx;
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               if (!phase_ff) begin
                  la_in    = {k_ff, frac_nx};
                  phase_in = 1'b1;
                  state_in = S_LOG_INIT;
               end else begin
                  lb       = {k_ff, frac_nx};
                  xneg_in  = la_ff < lb;
                  xmag_in  = (la_ff < lb) ? (lb - la_ff) : (la_ff - lb);
                  state_in = S_MUL_LO;
               end
            end
         end
         S_MUL_LO: begin
            mul_a    = xmag_ff[31:0];
            mul_b    = LN2_Q24;
            acc_in   = mul_p;
            state_in = S_MUL_HI;
         end
         S_MUL_HI: begin
            mul_a    = 32'(xmag_ff[LOG_W-1:32]);
            mul_b    = LN2_Q24;
            acc_in   = acc_ff + (mul_p << 32);
            state_in = S_DIV1;
         end
         S_DIV1: begin
            state_in = S_DIV1_WAIT;
         end
         S_DIV1_WAIT: begin
            if (div_rsp.done) begin
               // quotient truncates toward zero, sign from the log difference
               sq       = xneg_ff ? (64'd0 - div_rsp.quotient) : div_rsp.quotient;
               s_in     = $signed(sq) + INV_T25_Q56;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (s_ff == 64'sd0) begin
               temp_in[ch_ff] = TEMP_HIGH;
               state_in       = S_NEXT;
            end else if (s_ff < 64'sd0) begin
               temp_in[ch_ff] = TEMP_LOW;
               state_in       = S_NEXT;
            end else begin
               state_in = S_DIV2_WAIT;
            end
         end
         S_DIV2_WAIT: begin
            if (div_rsp.done) begin
               qs = div_rsp.quotient;
               if (qs > Q_SAT) begin
                  temp_in[ch_ff] = TEMP_HIGH;
               end else begin
                  if (qs >= KELVIN_X10) begin
                     v = $signed(17'(qs)) - $signed(17'(KELVIN_X10));
                  end else begin
                     v = $signed(17'(qs)) + $signed(17'(div_rsp.remainder != '0))
                         - $signed(17'(KELVIN_X10));
                  end
                  if (v < 17'(TEMP_LOW)) v = 17'(TEMP_LOW);
                  temp_in[ch_ff] = TEMP_W'(v);
               end
               state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (!ch_ff) begin
               ch_in    = 1'b1;
               state_in = S_CHAN;
            end else begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // output register frees the sequencer once the beat is loaded
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_tl_in    = temp_ff[0];
               rsp_tr_in    = temp_ff[1];
               rsp_flags_in = flag_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ch_ff        <= 1'b0;
         phase_ff     <= 1'b0;
         cnt_ff       <= '0;
         avg_ff[0]    <= '0;
         avg_ff[1]    <= '0;
         shift_ff     <= SHIFT_RESET;
         beta_ff      <= BETA_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ch_ff        <= ch_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         avg_ff       <= avg_in;
         shift_ff     <= shift_in;
         beta_ff      <= beta_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff         <= m_in;
      k_ff         <= k_in;
      frac_ff      <= frac_in;
      la_ff        <= la_in;
      xneg_ff      <= xneg_in;
      xmag_ff      <= xmag_in;
      acc_ff       <= acc_in;
      s_ff         <= s_in;
      temp_ff      <= temp_in;
      flag_ff      <= flag_in;
      rsp_tl_ff    <= rsp_tl_in;
      rsp_tr_ff    <= rsp_tr_in;
      rsp_flags_ff <= rsp_flags_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.temp_local  = rsp_tl_ff;
   assign rsp_bus.temp_remote = rsp_tr_ff;
   assign rsp_bus.rail_flags  = rsp_flags_ff;

endmodule

### sv/ntcat_checker.sv
`include "assert_macros.svh"

module ntcat_checker import ntcat_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [TEMP_W-1:0] temp_local,
   input logic signed [TEMP_W-1:0] temp_remote,
   input logic [1:0]               rail_flags
);

   `NTCAT_ASSERT_ALWAYS(a_no_beat_after_reset, clock, reset |=> !rsp_valid)
   `NTCAT_ASSERT(a_rail_local, clock, reset, rsp_valid && rail_flags[0] |-> temp_local == TEMP_LOW)
   `NTCAT_ASSERT(a_rail_remote, clock, reset, rsp_valid && rail_flags[1] |-> temp_remote == TEMP_LOW)
   `NTCAT_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(temp_local) && $stable(temp_remote) && $stable(rail_flags))

endmodule

bind ntc_average_to_temperature_core ntcat_checker u_ntcat_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .temp_local  (rsp_bus.temp_local),
   .temp_remote (rsp_bus.temp_remote),
   .rail_flags  (rsp_bus.rail_flags)
);

### verif/ntc_average_to_temperature_core_tb.sv
module ntc_average_to_temperature_core_tb;
   import ntcat_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADC_W = DEFAULT_ADC_BITS;
   localparam logic [63:0] FULL_SCALE = (64'd1 << ADC_W) - 64'd1;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic signed [TEMP_W-1:0] temp_local;
      logic signed [TEMP_W-1:0] temp_remote;
      logic [1:0]               rail_flags;
   } temp_beat_type;

   // thermistor averaging and beta-equation predictor with its own state
   class temp_scoreboard;
      logic [SHIFT_W-1:0] shift_cfg;
      logic [BETA_W-1:0]  beta_cfg;
      logic [ADC_W-1:0]   avg [2];
      temp_beat_type      pending [$];
      int                 mismatches;
      int                 results_seen;

      function new();
         shift_cfg = SHIFT_RESET;
         beta_cfg = BETA_RESET;
         avg[0] = '0;
         avg[1] = '0;
         mismatches = 0;
         results_seen = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         if (idx == CSR_AVERAGE_SHIFT) shift_cfg = val[SHIFT_W-1:0];
         else if (idx == CSR_BETA_VALUE) beta_cfg = val[BETA_W-1:0];
      endfunction

      // integer log2 in q32 by repeated squaring of the mantissa
      function logic [63:0] log2_fix(logic [63:0] n);
         logic [63:0] k, m, frac;
         k = 0;
         frac = 0;
         while (k < 31 && (n >> (k + 1)) != 0) k++;
         m = (n << (30 - k)) & 64'hFFFF_FFFF;
         for (int i = 0; i < 32; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
               m = m >> 1;
               frac[0] = 1'b1;
            end
         end
         return (k << 32) | (frac & 64'hFFFF_FFFF);
      endfunction

      function logic signed [TEMP_W-1:0] to_tenths(logic [63:0] a, output logic rail);
         logic signed [63:0] x, s, b, v;
         logic [63:0] q, r;
         rail = 1'b0;
         if (a == 0 || a >= FULL_SCALE) begin
            rail = 1'b1;
            return TEMP_LOW;
         end
         b = (beta_cfg == 0) ? 64'sd1 : $signed({50'd0, beta_cfg});
         x = $signed(log2_fix(a)) - $signed(log2_fix(FULL_SCALE - a));
         s = (x * $signed({32'd0, LN2_Q24})) / b + INV_T25_Q56;
         if (s == 0) return TEMP_HIGH;
         if (s < 0) return TEMP_LOW;
         q = TEN_Q56 / s;
         r = TEN_Q56 % s;
         if (q > Q_SAT) return TEMP_HIGH;
         if (q >= KELVIN_X10) v = $signed(q) - 64'sd2731;
         else v = $signed(q) + ((r != 0) ? 64'sd1 : 64'sd0) - 64'sd2731;
         if (v < -64'sd2731) v = -64'sd2731;
         if (v > 64'sd20000) v = 64'sd20000;
         return v[TEMP_W-1:0];
      endfunction

      function void note_samples(logic [ADC_W-1:0] s_loc, logic [ADC_W-1:0] s_rem);
         logic [63:0]   weight, nv, smp;
         logic          changed, rl, rr;
         temp_beat_type e;
         changed = 1'b0;
         weight = (64'd1 << shift_cfg) - 64'd1;
         for (int c = 0; c < 2; c++) begin
            smp = (c == 0) ? 64'(s_loc) : 64'(s_rem);
            nv = ((64'(avg[c]) * weight + smp) >> shift_cfg) & FULL_SCALE;
            if (nv[ADC_W-1:0] != avg[c]) begin
               avg[c] = nv[ADC_W-1:0];
               changed = 1'b1;
            end
         end
         if (!changed) return;
         e.temp_local = to_tenths(64'(avg[0]), rl);
         e.temp_remote = to_tenths(64'(avg[1]), rr);
         e.rail_flags = {rr, rl};
         pending.push_back(e);
      endfunction

      function void check_result(temp_beat_type got);
         temp_beat_type e;
         results_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: %p", got);
            return;
         end
         e = pending.pop_front();
         if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp loc %0d rem %0d rail %b, got loc %0d rem %0d rail %b",
                        e.temp_local, e.temp_remote, e.rail_flags,
                        got.temp_local, got.temp_remote, got.rail_flags);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   ntcat_req_if #(.ADC_BITS(ADC_W)) req_bus ();
   ntcat_rsp_if rsp_bus ();
   ntcat_csr_if csr_bus ();

   ntc_average_to_temperature_core #(.ADC_BITS(ADC_W)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus.sink),
      .rsp_bus(rsp_bus.source),
      .csr_bus(csr_bus.sink)
   );

   always #6 clock = ~clock;

   temp_scoreboard sb = new();
   int  send_idle_pct;   // chance in percent that the sender idles a cycle
   int  recv_stall_pct;  // chance in percent that the receiver stalls a cycle
   int  quiet_cycles;
   int  beats_sent;
   bit  timed_out;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.sample_local = '0;
      req_bus.sample_remote = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.wdata = '0;
   end

   // receiver side: random ready, result beats checked at the rising edge
   always @(negedge clock) begin
      if (!reset) rsp_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result({rsp_bus.temp_local, rsp_bus.temp_remote, rsp_bus.rail_flags});
   end

   // watchdog on cycles in which no beat moves on any channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   always @(posedge clock) begin
      if (quiet_cycles >= STALL_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
         $display("ntc_average_to_temperature_core_tb: done, errors");
         $finish;
      end
   end

   // one sample beat, gaps before it at the sender idle rate
   task automatic send_samples(logic [ADC_W-1:0] s_loc, logic [ADC_W-1:0] s_rem);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req_bus.valid = 1'b1;
      req_bus.sample_local = s_loc;
      req_bus.sample_remote = s_rem;
      do @(posedge clock); while (!req_bus.ready);
      sb.note_samples(s_loc, s_rem);
      beats_sent++;
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.wdata = val;
      do @(posedge clock); while (!csr_bus.ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // drain every expected result, then cover the tail of a no-change beat
   task automatic wait_idle();
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (500) @(negedge clock);
   endtask

   task automatic set_config(logic [SHIFT_W-1:0] sh, logic [BETA_W-1:0] be);
      wait_idle();
      write_csr(CSR_AVERAGE_SHIFT, CSR_DATA_W'(sh));
      write_csr(CSR_BETA_VALUE, CSR_DATA_W'(be));
   endtask

   // mostly mid-scale codes, some rails and extremes
   task automatic random_samples(int count);
      logic [ADC_W-1:0] a, b;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: a = '0;
            1: a = '1;
            2: a = ADC_W'($urandom_range(1023));
            default: a = ADC_W'($urandom_range(900, 100));
         endcase
         case ($urandom_range(9))
            0: b = '0;
            1: b = '1;
            2: b = ADC_W'($urandom_range(1023));
            default: b = ADC_W'($urandom_range(900, 100));
         endcase
         send_samples(a, b);
      end
   endtask

   initial begin
      beats_sent = 0;
      timed_out = 1'b0;
      send_idle_pct = 34;
      recv_stall_pct = 80;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: pass-through so averages follow samples directly
      write_csr(CSR_AVERAGE_SHIFT, CSR_DATA_W'(0));
      send_samples('0, '0);          // no change from reset, no result
      send_samples('1, '0);          // full scale rail on local
      send_samples(10'd512, '1);     // mid code, remote at rail
      send_samples(10'd1, 10'd1022); // one step inside each rail
      send_samples(10'd1022, 10'd1);
      send_samples(10'd341, 10'd682);
      send_samples(10'h155, 10'h2AA);
      send_samples(10'h2AA, 10'h155);
      send_samples(10'h2AA, 10'h155); // repeat, no result
      send_samples('0, '1);
      // small beta can make 1/t nonpositive; zero beta treated as one
      wait_idle();
      write_csr(CSR_BETA_VALUE, CSR_DATA_W'(0));
      send_samples(10'd1, 10'd1022);
      send_samples(10'd1022, 10'd1);
      set_config(4'd0, 14'd1);
      send_samples(10'd2, 10'd1000);
      send_samples(10'd1021, 10'd20);
      set_config(4'd0, 14'h3FFF);
      send_samples(10'd3, 10'd700);
      // shifts above the normal range
      set_config(4'd15, 14'd1000);
      send_samples('1, '1);
      send_samples('1, '1);
      set_config(4'd9, 14'd10000);
      send_samples('1, 10'd500);

      // random phases across several settings
      set_config(4'd4, 14'd3380);
      random_samples(110);
      set_config(4'd8, 14'd1000);
      random_samples(80);
      send_idle_pct = 80;
      recv_stall_pct = 34;
      set_config(4'd1, 14'd10000);
      random_samples(110);
      set_config(4'd0, 14'd4250);
      random_samples(80);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      set_config(4'd2, 14'($urandom_range(10000, 1000)));
      random_samples(80);
      set_config(4'd0, 14'd3380);
      random_samples(70);

      wait_idle();
      $display("covered %0d sample beats and %0d result beats over shifts 0..15 and beta 0..16383",
               beats_sent, sb.results_seen);
      if (sb.mismatches == 0) begin
         $display("ntc_average_to_temperature_core_tb: done, clean");
      end else begin
         $display("%0d mismatches", sb.mismatches);
         $display("ntc_average_to_temperature_core_tb: done, errors");
      end
      $finish;
   end
endmodule
